// ===== design/cicp_pkg.sv =====
// cicp_pkg: request/response payload types, action codes, reset values and
// the priority helper shared by the cascaded interrupt controller pair.
// Depends on nothing.
`default_nettype none

package cicp_pkg;

	// action codes carried by a request
	localparam logic [2:0] ACT_READ  = 3'd0;
	localparam logic [2:0] ACT_WRITE = 3'd1;
	localparam logic [2:0] ACT_RAISE = 3'd2;
	localparam logic [2:0] ACT_CLEAR = 3'd3;
	localparam logic [2:0] ACT_ACK   = 3'd4;
	localparam logic [2:0] ACT_EOI   = 3'd5;
	localparam logic [2:0] ACT_SCAN  = 3'd6;
	localparam logic [2:0] ACT_POLL  = 3'd7;

	// port decode and command word bits
	localparam logic [7:0] SLAVE_PORT_BASE = 8'hA0;
	localparam int         ICW1_BIT        = 4;
	localparam int         EOI_BIT         = 5;
	localparam logic [7:0] BASE_MASK       = 8'hF8;

	// cascade wiring and special codes
	localparam logic [2:0] CASCADE_LINE  = 3'd2;
	localparam logic [2:0] SPURIOUS_LINE = 3'd7;
	localparam logic [4:0] SCAN_HIT_TAG  = 5'b10000;
	localparam logic [7:0] SCAN_NONE     = 8'd7;

	// reset values of the two chips
	localparam logic [7:0] MASTER_MASK_RST = 8'hB8;
	localparam logic [7:0] SLAVE_MASK_RST  = 8'h9D;
	localparam logic [7:0] MASTER_BASE_RST = 8'h08;
	localparam logic [7:0] SLAVE_BASE_RST  = 8'h70;

	typedef struct packed {
		logic [2:0]        action;
		logic [7:0]        port;
		logic              chip;
		logic [7:0]        write_data;
		logic [2:0]        irq_line;
		logic signed [3:0] raise_count;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] vector;
		logic       cpu_signal;
		logic [7:0] scan_code;
		logic       eoi_found;
		logic [2:0] eoi_line;
	} rsp_t;

	// update command into one chip
	typedef struct packed {
		logic       wr_even;
		logic       wr_odd;
		logic [7:0] data;
		logic [7:0] set_req;
		logic [7:0] clr_req;
		logic [7:0] set_isr;
		logic       eoi;
	} chip_cmd_t;

	// register view of one chip
	typedef struct packed {
		logic [7:0] req;
		logic [7:0] isr;
		logic [7:0] mask;
		logic [7:0] base;
	} chip_view_t;

	typedef struct packed {
		chip_view_t cur;
		chip_view_t nxt;
	} chip_stat_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} lowest_t;

	// fixed priority: lowest set bit wins
	function automatic lowest_t lowest_set(input logic [7:0] v);
		lowest_t r;
		r.hit = 1'b0;
		r.idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				r.hit = 1'b1;
				r.idx = 3'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/cicp_chip.sv =====
// cicp_chip: register file and init sequencer of one 8259-style controller.
// Depends on cicp_pkg for the command and status structs.
`default_nettype none

module cicp_chip #(
	parameter logic [7:0] MASK_RST = 8'hB8,
	parameter logic [7:0] BASE_RST = 8'h08
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  cicp_pkg::chip_cmd_t   cmd,
	output cicp_pkg::chip_stat_t  stat
);

	// init sequencer phases
	localparam logic [1:0] PH_RUN  = 2'd0;
	localparam logic [1:0] PH_BASE = 2'd1;
	localparam logic [1:0] PH_ICW3 = 2'd2;
	localparam logic [1:0] PH_ICW4 = 2'd3;

	logic [7:0] req_q, isr_q, mask_q, base_q;
	logic [1:0] phase_q;
	logic       want4_q;

	logic [7:0] req_d, isr_d, mask_d, base_d;
	logic [1:0] phase_d;
	logic       want4_d;
	cicp_pkg::lowest_t isr_low;

	assign isr_low = cicp_pkg::lowest_set(isr_q);

	// next-state logic
	always_comb begin
		req_d   = (req_q | cmd.set_req) & ~cmd.clr_req;
		isr_d   = isr_q | cmd.set_isr;
		mask_d  = mask_q;
		base_d  = base_q;
		phase_d = phase_q;
		want4_d = want4_q;
		if (cmd.wr_even && cmd.data[cicp_pkg::ICW1_BIT]) begin
			req_d   = 8'h00;
			isr_d   = 8'h00;
			phase_d = PH_BASE;
			want4_d = cmd.data[0];
		end else if ((cmd.wr_even && cmd.data[cicp_pkg::EOI_BIT]) || cmd.eoi) begin
			if (isr_low.hit)
				isr_d[isr_low.idx] = 1'b0;
		end
		if (cmd.wr_odd) begin
			case (phase_q)
				PH_BASE: begin
					base_d  = cmd.data & cicp_pkg::BASE_MASK;
					phase_d = PH_ICW3;
				end
				PH_ICW3: phase_d = want4_q ? PH_ICW4 : PH_RUN;
				PH_ICW4: phase_d = PH_RUN;
				default: mask_d = cmd.data;
			endcase
		end
	end

	// chip registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q   <= 8'h00;
			isr_q   <= 8'h00;
			mask_q  <= MASK_RST;
			base_q  <= BASE_RST;
			phase_q <= PH_RUN;
			want4_q <= 1'b0;
		end else begin
			req_q   <= req_d;
			isr_q   <= isr_d;
			mask_q  <= mask_d;
			base_q  <= base_d;
			phase_q <= phase_d;
			want4_q <= want4_d;
		end
	end

	assign stat.cur = '{req: req_q, isr: isr_q, mask: mask_q, base: base_q};
	assign stat.nxt = '{req: req_d, isr: isr_d, mask: mask_d, base: base_d};

endmodule

`default_nettype wire

// ===== design/cascaded_interrupt_controller_pair_core.sv =====
// cascaded_interrupt_controller_pair_core: master/slave interrupt controller
// pair with request register, decode logic and response register.
// Depends on cicp_pkg and cicp_chip.
`default_nettype none

// A request is taken into an input register, then decoded and applied to the
// two chip register files from that register. Its response is registered
// at the same edge that updates the chip registers. One request is taken per
// cycle while the response is not stalled, with no gaps; the figure is set by
// the read-modify-write of the chip registers (priority encode plus bit
// update) done at that edge. A stalled response holds the input register,
// and the input takes a new request whenever that register is free or
// draining.
module cascaded_interrupt_controller_pair_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  cicp_pkg::req_t   in_data,
	output logic             out_valid,
	input  wire              out_ready,
	output cicp_pkg::rsp_t   out_data
);

	logic            valid_s1;
	cicp_pkg::req_t  req_s1;
	logic            advance;
	logic            fire;

	cicp_pkg::chip_cmd_t  m_cmd, s_cmd;
	cicp_pkg::chip_stat_t m_stat, s_stat;
	cicp_pkg::rsp_t       rsp;
	cicp_pkg::rsp_t       out_q;
	logic                 out_valid_q;

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			req_s1 <= in_data;
	end

	cicp_chip #(
		.MASK_RST (cicp_pkg::MASTER_MASK_RST),
		.BASE_RST (cicp_pkg::MASTER_BASE_RST)
	) u_master (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (m_cmd),
		.stat   (m_stat)
	);

	cicp_chip #(
		.MASK_RST (cicp_pkg::SLAVE_MASK_RST),
		.BASE_RST (cicp_pkg::SLAVE_BASE_RST)
	) u_slave (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (s_cmd),
		.stat   (s_stat)
	);

	// decode and response logic
	logic              port_slave, sel_slave, positive;
	logic [7:0]        line_bit;
	logic [7:0]        m_pend, s_pend, sel_pend, sel_isr;
	cicp_pkg::lowest_t m_win, s_win, sel_win, isr_win;
	logic [7:0]        m_win_bit, s_win_bit;
	logic              m_nxt_pend;
	cicp_pkg::chip_view_t port_view;

	assign port_slave = req_s1.port >= cicp_pkg::SLAVE_PORT_BASE;
	assign sel_slave  = req_s1.chip;
	assign positive   = (req_s1.raise_count != 4'sd0) && !req_s1.raise_count[3];
	assign line_bit   = 8'h01 << req_s1.irq_line;
	assign m_pend     = m_stat.cur.req & ~m_stat.cur.mask;
	assign s_pend     = s_stat.cur.req & ~s_stat.cur.mask;
	assign sel_pend   = sel_slave ? s_pend : m_pend;
	assign sel_isr    = sel_slave ? s_stat.cur.isr : m_stat.cur.isr;
	assign m_win      = cicp_pkg::lowest_set(m_pend);
	assign s_win      = cicp_pkg::lowest_set(s_pend);
	assign sel_win    = cicp_pkg::lowest_set(sel_pend);
	assign isr_win    = cicp_pkg::lowest_set(sel_isr);
	assign m_win_bit  = 8'h01 << m_win.idx;
	assign s_win_bit  = 8'h01 << s_win.idx;
	assign m_nxt_pend = |(m_stat.nxt.req & ~m_stat.nxt.mask);
	assign port_view  = port_slave ? s_stat.cur : m_stat.cur;

	always_comb begin
		m_cmd = '0;
		s_cmd = '0;
		rsp   = '0;
		m_cmd.data = req_s1.write_data;
		s_cmd.data = req_s1.write_data;
		case (req_s1.action)
			cicp_pkg::ACT_READ: begin
				rsp.read_data = req_s1.port[0] ? port_view.mask : port_view.req;
			end
			cicp_pkg::ACT_WRITE: begin
				if (port_slave) begin
					s_cmd.wr_even = fire && !req_s1.port[0];
					s_cmd.wr_odd  = fire && req_s1.port[0];
				end else begin
					m_cmd.wr_even = fire && !req_s1.port[0];
					m_cmd.wr_odd  = fire && req_s1.port[0];
				end
				rsp.cpu_signal = m_nxt_pend;
			end
			cicp_pkg::ACT_RAISE: begin
				if (positive) begin
					if (sel_slave) begin
						s_cmd.set_req = fire ? line_bit : 8'h00;
						m_cmd.set_req = fire ? (8'h01 << cicp_pkg::CASCADE_LINE) : 8'h00;
					end else begin
						m_cmd.set_req = fire ? line_bit : 8'h00;
					end
					rsp.cpu_signal = m_nxt_pend;
				end
			end
			cicp_pkg::ACT_CLEAR: begin
				if (sel_slave)
					s_cmd.clr_req = fire ? line_bit : 8'h00;
				else
					m_cmd.clr_req = fire ? line_bit : 8'h00;
			end
			cicp_pkg::ACT_ACK: begin
				if (!m_win.hit) begin
					rsp.vector = m_stat.cur.base + 8'(cicp_pkg::SPURIOUS_LINE);
				end else begin
					m_cmd.clr_req = fire ? m_win_bit : 8'h00;
					m_cmd.set_isr = fire ? m_win_bit : 8'h00;
					if (m_win.idx == cicp_pkg::CASCADE_LINE && s_win.hit) begin
						s_cmd.clr_req = fire ? s_win_bit : 8'h00;
						s_cmd.set_isr = fire ? s_win_bit : 8'h00;
						rsp.vector    = s_stat.cur.base + 8'(s_win.idx);
					end else begin
						rsp.vector = m_stat.cur.base + 8'(m_win.idx);
					end
				end
			end
			cicp_pkg::ACT_EOI: begin
				if (sel_slave)
					s_cmd.eoi = fire;
				else
					m_cmd.eoi = fire;
				rsp.eoi_found = isr_win.hit;
				rsp.eoi_line  = isr_win.hit ? isr_win.idx : 3'd0;
			end
			cicp_pkg::ACT_SCAN: begin
				rsp.scan_code = sel_win.hit ? {cicp_pkg::SCAN_HIT_TAG, sel_win.idx}
				                            : cicp_pkg::SCAN_NONE;
			end
			default: begin
				rsp.cpu_signal = m_nxt_pend;
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_q <= rsp;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// a stalled response keeps the request stage occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("request stage dropped while response stalled");

	// a nonzero eoi line only comes with a found in-service bit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.eoi_line != 3'd0 |-> out_data.eoi_found)
		else $error("eoi line without eoi found");

	// scan codes are zero, the none code, or tagged line numbers
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.scan_code == 8'd0 || out_data.scan_code == cicp_pkg::SCAN_NONE
			|| out_data.scan_code[7:3] == cicp_pkg::SCAN_HIT_TAG))
		else $error("malformed scan code");

	// eoi and acknowledge results never share a response
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.eoi_found |-> out_data.vector == 8'd0
			&& out_data.cpu_signal == 1'b0)
		else $error("eoi response carries other results");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: self-checking bench for cascaded_interrupt_controller_pair_core.
// A directed table and random request streams are checked against a predictor.
// Depends on cicp_pkg and the core RTL.
`default_nettype none

module testbench;
	import cicp_pkg::*;

	localparam int RANDOM_REQUESTS = 1200;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 6;
	localparam int MAX_REPORTS     = 10;

	typedef enum logic [1:0] {
		INIT_DONE    = 2'd0,
		INIT_BASE    = 2'd1,
		INIT_CASCADE = 2'd2,
		INIT_MODE    = 2'd3
	} init_phase_e;

	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	// predictor copy of both chips
	logic [7:0]  pend_bits [2];
	logic [7:0]  serv_bits [2];
	logic [7:0]  mask_bits [2];
	logic [7:0]  base_bits [2];
	init_phase_e icw_phase [2];
	logic        icw4_wanted [2];

	rsp_t pending_responses [$];
	int   mismatch_count = 0;
	int   quiet_cycles = 0;
	int   src_idle_pct = 0;
	int   sink_idle_pct = 0;

	stim_row_t directed_rows [$];

	cascaded_interrupt_controller_pair_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// lowest set bit, 8 when none
	function automatic logic [3:0] lowest_line(input logic [7:0] v);
		logic [3:0] w;
		w = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (v[i] && w[3])
				w = 4'(i);
		end
		return w;
	endfunction

	function automatic logic master_wants_cpu();
		return (pend_bits[0] & ~mask_bits[0]) != 8'h00;
	endfunction

	// applies one request to the predictor state and returns its response
	function automatic rsp_t pic_response(input req_t r);
		rsp_t o;
		logic [3:0] w;
		logic [3:0] s;
		logic pc;
		logic c;
		o = '0;
		pc = r.port >= SLAVE_PORT_BASE;
		c = r.chip;
		case (r.action)
			ACT_READ: begin
				o.read_data = r.port[0] ? mask_bits[pc] : pend_bits[pc];
			end
			ACT_WRITE: begin
				if (!r.port[0]) begin
					if (r.write_data[ICW1_BIT]) begin
						pend_bits[pc] = 8'h00;
						serv_bits[pc] = 8'h00;
						icw_phase[pc] = INIT_BASE;
						icw4_wanted[pc] = r.write_data[0];
					end else if (r.write_data[EOI_BIT]) begin
						w = lowest_line(serv_bits[pc]);
						if (!w[3])
							serv_bits[pc][w[2:0]] = 1'b0;
					end
				end else begin
					case (icw_phase[pc])
						INIT_BASE: begin
							base_bits[pc] = r.write_data & BASE_MASK;
							icw_phase[pc] = INIT_CASCADE;
						end
						INIT_CASCADE: icw_phase[pc] = icw4_wanted[pc] ? INIT_MODE : INIT_DONE;
						INIT_MODE: icw_phase[pc] = INIT_DONE;
						default: mask_bits[pc] = r.write_data;
					endcase
				end
				o.cpu_signal = master_wants_cpu();
			end
			ACT_RAISE: begin
				if (r.raise_count > 0) begin
					pend_bits[c][r.irq_line] = 1'b1;
					if (c)
						pend_bits[0][CASCADE_LINE] = 1'b1;
					o.cpu_signal = master_wants_cpu();
				end
			end
			ACT_CLEAR: begin
				pend_bits[c][r.irq_line] = 1'b0;
			end
			ACT_ACK: begin
				w = lowest_line(pend_bits[0] & ~mask_bits[0]);
				if (w[3]) begin
					o.vector = base_bits[0] + 8'(SPURIOUS_LINE);
				end else begin
					pend_bits[0][w[2:0]] = 1'b0;
					serv_bits[0][w[2:0]] = 1'b1;
					o.vector = base_bits[0] + 8'(w[2:0]);
					// cascade through the slave
					if (w[2:0] == CASCADE_LINE) begin
						s = lowest_line(pend_bits[1] & ~mask_bits[1]);
						if (!s[3]) begin
							pend_bits[1][s[2:0]] = 1'b0;
							serv_bits[1][s[2:0]] = 1'b1;
							o.vector = base_bits[1] + 8'(s[2:0]);
						end
					end
				end
			end
			ACT_EOI: begin
				w = lowest_line(serv_bits[c]);
				if (!w[3]) begin
					serv_bits[c][w[2:0]] = 1'b0;
					o.eoi_found = 1'b1;
					o.eoi_line = w[2:0];
				end
			end
			ACT_SCAN: begin
				w = lowest_line(pend_bits[c] & ~mask_bits[c]);
				o.scan_code = w[3] ? SCAN_NONE : {SCAN_HIT_TAG, w[2:0]};
			end
			default: o.cpu_signal = master_wants_cpu();
		endcase
		return o;
	endfunction

	function automatic req_t mk_req(input logic [2:0] act, input logic [7:0] port,
			input logic chip, input logic [7:0] data, input logic [2:0] line,
			input logic signed [3:0] cnt);
		req_t r;
		r.action = act;
		r.port = port;
		r.chip = chip;
		r.write_data = data;
		r.irq_line = line;
		r.raise_count = cnt;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(input logic [7:0] rd, input logic [7:0] vec,
			input logic sig, input logic [7:0] scan);
		rsp_t o;
		o = '0;
		o.read_data = rd;
		o.vector = vec;
		o.cpu_signal = sig;
		o.scan_code = scan;
		return o;
	endfunction

	// port of one chip, usually the standard pair, sometimes any alias
	function automatic logic [7:0] chip_port(input logic chip, input logic odd);
		logic [7:0] p;
		if ($urandom_range(99) < 70)
			p = chip ? SLAVE_PORT_BASE : 8'h20;
		else
			p = chip ? 8'($urandom_range(8'hA0, 8'hFF)) : 8'($urandom_range(0, 8'h9F));
		p[0] = odd;
		return p;
	endfunction

	// one random request, biased toward traffic that keeps interrupts moving
	function automatic req_t random_request();
		req_t r;
		int roll;
		r = req_t'({$urandom, $urandom});
		roll = $urandom_range(99);
		if (roll < 25)
			r.action = ACT_RAISE;
		else if (roll < 40)
			r.action = ACT_ACK;
		else if (roll < 52)
			r.action = ACT_EOI;
		else if (roll < 70)
			r.action = ACT_WRITE;
		else if (roll < 78)
			r.action = ACT_READ;
		else if (roll < 86)
			r.action = ACT_SCAN;
		else if (roll < 93)
			r.action = ACT_CLEAR;
		else
			r.action = ACT_POLL;
		if ($urandom_range(99) < 75)
			r.raise_count = 4'($urandom_range(1, 7));
		if ($urandom_range(99) < 80)
			r.port = chip_port(r.chip, r.port[0]);
		if (r.action == ACT_WRITE) begin
			if (!r.port[0]) begin
				// mostly eoi commands, now and then a stray init word
				if ($urandom_range(99) < 60)
					r.write_data[EOI_BIT] = 1'b1;
				if ($urandom_range(99) >= 3)
					r.write_data[ICW1_BIT] = 1'b0;
			end else if ($urandom_range(99) < 70) begin
				r.write_data = 8'($urandom & $urandom & $urandom);
			end
		end
		return r;
	endfunction

	// present one request and hold it until it is taken
	task automatic send_request(input req_t r, input rsp_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		pending_responses.push_back(want);
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_predicted(input req_t r);
		send_request(r, pic_response(r));
	endtask

	task automatic await_all_responses();
		in_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	// full init word sequence for one chip
	task automatic send_init_sequence(input logic chip, output int sent);
		logic [7:0] icw1;
		logic four;
		icw1 = 8'($urandom);
		icw1[ICW1_BIT] = 1'b1;
		four = icw1[0];
		send_predicted(mk_req(ACT_WRITE, chip_port(chip, 1'b0), 1'b0, icw1, 3'd0, 4'sd0));
		send_predicted(mk_req(ACT_WRITE, chip_port(chip, 1'b1), 1'b0, 8'($urandom), 3'd0,
			4'sd0));
		send_predicted(mk_req(ACT_WRITE, chip_port(chip, 1'b1), 1'b0, 8'($urandom), 3'd0,
			4'sd0));
		sent = 3;
		if (four) begin
			send_predicted(mk_req(ACT_WRITE, chip_port(chip, 1'b1), 1'b0, 8'($urandom), 3'd0,
				4'sd0));
			sent = 4;
		end
	endtask

	// response checking and receiver stalls
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_responses.size() == 0) begin
				mismatch_count <= mismatch_count + 1;
				if (mismatch_count < MAX_REPORTS)
					$display("unexpected response %h", out_data);
			end else begin
				want = pending_responses.pop_front();
				if (out_data.read_data !== want.read_data || out_data.vector !== want.vector ||
						out_data.cpu_signal !== want.cpu_signal ||
						out_data.scan_code !== want.scan_code ||
						out_data.eoi_found !== want.eoi_found ||
						out_data.eoi_line !== want.eoi_line) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < MAX_REPORTS) begin
						$display("response mismatch: expected rd=%h vec=%h sig=%b scan=%h eoi=%b/%0d",
							want.read_data, want.vector, want.cpu_signal, want.scan_code,
							want.eoi_found, want.eoi_line);
						$display("                   got      rd=%h vec=%h sig=%b scan=%h eoi=%b/%0d",
							out_data.read_data, out_data.vector, out_data.cpu_signal,
							out_data.scan_code, out_data.eoi_found, out_data.eoi_line);
					end
				end
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		int sent;
		int i;
		bit drained;
		// reset state of the predictor
		pend_bits = '{8'h00, 8'h00};
		serv_bits = '{8'h00, 8'h00};
		mask_bits = '{MASTER_MASK_RST, SLAVE_MASK_RST};
		base_bits = '{MASTER_BASE_RST, SLAVE_BASE_RST};
		icw_phase = '{INIT_DONE, INIT_DONE};
		icw4_wanted = '{1'b0, 1'b0};

		directed_rows = '{
			// reset values and extremes
			'{mk_req(ACT_READ, 8'h20, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b1,
				mk_rsp(8'h00, 8'h00, 1'b0, 8'h00)},
			'{mk_req(ACT_READ, 8'h21, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b1,
				mk_rsp(8'hB8, 8'h00, 1'b0, 8'h00)},
			'{mk_req(ACT_READ, 8'hA1, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b1,
				mk_rsp(8'h9D, 8'h00, 1'b0, 8'h00)},
			'{mk_req(ACT_READ, 8'hA0, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b1,
				mk_rsp(8'h00, 8'h00, 1'b0, 8'h00)},
			// spurious acknowledge and empty scan
			'{mk_req(ACT_ACK, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b1,
				mk_rsp(8'h00, 8'h0F, 1'b0, 8'h00)},
			'{mk_req(ACT_SCAN, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b1,
				mk_rsp(8'h00, 8'h00, 1'b0, 8'h07)},
			// raises with zero and negative count are ignored, a positive one is taken
			'{mk_req(ACT_RAISE, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b1,
				mk_rsp(8'h00, 8'h00, 1'b0, 8'h00)},
			'{mk_req(ACT_RAISE, 8'h00, 1'b0, 8'h00, 3'd0, -4'sd8), 1'b1,
				mk_rsp(8'h00, 8'h00, 1'b0, 8'h00)},
			'{mk_req(ACT_RAISE, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd7), 1'b1,
				mk_rsp(8'h00, 8'h00, 1'b1, 8'h00)},
			// slave raise, cascaded acknowledge, eoi on both chips
			'{mk_req(ACT_RAISE, 8'h00, 1'b1, 8'h00, 3'd1, 4'sd1), 1'b0, '0},
			'{mk_req(ACT_SCAN, 8'h00, 1'b1, 8'h00, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_ACK, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_ACK, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_EOI, 8'h00, 1'b1, 8'h00, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_EOI, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_EOI, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_CLEAR, 8'h00, 1'b0, 8'h00, 3'd7, 4'sd0), 1'b0, '0},
			// mask everything, poll
			'{mk_req(ACT_WRITE, 8'h21, 1'b0, 8'hFF, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_POLL, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b0, '0},
			// init sequence with fourth word and extreme base
			'{mk_req(ACT_WRITE, 8'h20, 1'b0, 8'h11, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_WRITE, 8'h21, 1'b0, 8'hFF, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_WRITE, 8'h21, 1'b0, 8'h04, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_WRITE, 8'h21, 1'b0, 8'h01, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_WRITE, 8'h21, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b0, '0},
			'{mk_req(ACT_RAISE, 8'h00, 1'b0, 8'h00, 3'd7, 4'sd3), 1'b0, '0},
			'{mk_req(ACT_ACK, 8'h00, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b0, '0},
			// top port alias writes the slave mask
			'{mk_req(ACT_WRITE, 8'hFF, 1'b0, 8'h00, 3'd0, 4'sd0), 1'b0, '0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		src_idle_pct = 16;
		sink_idle_pct = 63;
		foreach (directed_rows[k]) begin
			if (directed_rows[k].typed) begin
				void'(pic_response(directed_rows[k].rq));
				send_request(directed_rows[k].rq, directed_rows[k].want);
			end else begin
				send_predicted(directed_rows[k].rq);
			end
		end
		await_all_responses();

		// random traffic in three idling phases
		i = 0;
		drained = 1'b0;
		while (i < RANDOM_REQUESTS) begin
			if (i >= 2 * RANDOM_REQUESTS / 3) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end else if (i >= RANDOM_REQUESTS / 3) begin
				src_idle_pct = 63;
				sink_idle_pct = 16;
			end
			// hold off once mid-run until the pipeline is empty
			if (!drained && i >= RANDOM_REQUESTS / 2) begin
				await_all_responses();
				drained = 1'b1;
			end
			if ($urandom_range(99) < 4) begin
				send_init_sequence(1'($urandom), sent);
				i += sent;
			end else begin
				send_predicted(random_request());
				i++;
			end
		end
		await_all_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_responses.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
